/* design/xfse_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the xor float series encoder
// depends on nothing; every other file of the block except xfse_out_if imports it
package xfse_pkg;

    localparam int WORD_BITS    = 64;
    localparam int WORD_BYTES   = 8;
    localparam int HEADER_BYTES = 3;
    localparam int WIDE_LIMIT   = 9;

    // command queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // marker bytes of the stream
    localparam logic [7:0] MARK_ZERO   = 8'd0;
    localparam logic [7:0] MARK_NARROW = 8'd1;
    localparam logic [7:0] MARK_WIDE   = 8'd2;

    typedef enum logic [1:0] {
        K_RAW    = 2'd0,
        K_ZERO   = 2'd1,
        K_NARROW = 2'd2,
        K_WIDE   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [WORD_BITS-1:0]  word;  // raw sample or xor
        logic [2:0]            lead;  // leading zero bytes, narrow form
        logic [2:0]            span;  // window width, narrow form
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* design/xfse_in_if.sv */
`timescale 1ns / 1ps
// input channel of the encoder: one 64-bit sample per beat
// depends on xfse_pkg
interface xfse_in_if;
    import xfse_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] value_bits;
    logic                 first_of_series;

    modport source (output valid, output value_bits, output first_of_series, input ready);
    modport sink   (input valid, input value_bits, input first_of_series, output ready);
endinterface

/* design/xfse_out_if.sv */
`timescale 1ns / 1ps
// output channel of the encoder: one stream byte per beat
// depends on nothing
interface xfse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_last;

    modport source (output valid, output out_byte, output byte_last, input ready);
    modport sink   (input valid, input out_byte, input byte_last, output ready);
endinterface

/* design/xfse_front.sv */
`timescale 1ns / 1ps
// front part: takes samples, keeps history, classifies each into a command
// depends on xfse_pkg
module xfse_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [xfse_pkg::WORD_BITS-1:0]  i_value_bits,
    input  logic                            i_first_of_series,
    input  xfse_pkg::t_q_stat               i_q_stat,
    output logic                            o_push,
    output xfse_pkg::t_cmd                  o_cmd
);
    import xfse_pkg::*;

    logic [WORD_BITS-1:0]  r_prev;
    logic [WORD_BITS-1:0]  x;
    logic [WORD_BYTES-1:0] nz;
    logic [3:0]            lead;
    logic [3:0]            trail;
    logic [3:0]            span;
    logic                  hit_hi;
    logic                  hit_lo;

    // no beat is taken while reset is held
    assign o_ready = i_rst_n && !i_q_stat.full;
    assign o_push  = i_valid && o_ready;
    assign x       = r_prev ^ i_value_bits;

    always_comb begin
        for (int i = 0; i < WORD_BYTES; i++) begin
            nz[i] = |x[i*8 +: 8];
        end
    end

    // zero-byte counts from both ends
    always_comb begin
        lead   = 4'd0;
        trail  = 4'd0;
        hit_hi = 1'b0;
        hit_lo = 1'b0;
        for (int i = WORD_BYTES - 1; i >= 0; i--) begin
            if (!hit_hi) begin
                if (nz[i]) begin
                    hit_hi = 1'b1;
                end else begin
                    lead = lead + 4'd1;
                end
            end
        end
        for (int i = 0; i < WORD_BYTES; i++) begin
            if (!hit_lo) begin
                if (nz[i]) begin
                    hit_lo = 1'b1;
                end else begin
                    trail = trail + 4'd1;
                end
            end
        end
    end

    assign span = 4'(WORD_BYTES) - lead - trail;

    always_comb begin
        o_cmd.word = i_first_of_series ? i_value_bits : x;
        o_cmd.lead = lead[2:0];
        o_cmd.span = span[2:0];
        if (i_first_of_series) begin
            o_cmd.kind = K_RAW;
        end else if (nz == '0) begin
            o_cmd.kind = K_ZERO;
        end else if ((5'(span) + 5'(HEADER_BYTES)) < 5'(WIDE_LIMIT)) begin
            o_cmd.kind = K_NARROW;
        end else begin
            o_cmd.kind = K_WIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (o_push) begin
            r_prev <= i_value_bits;
        end
    end

endmodule

/* design/xfse_fifo.sv */
`timescale 1ns / 1ps
// short command queue between front and back
// depends on xfse_pkg
module xfse_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  xfse_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output xfse_pkg::t_cmd    o_cmd,
    output xfse_pkg::t_q_stat o_q_stat
);
    import xfse_pkg::*;

    t_cmd             r_slot [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(FIFO_DEPTH - 1)) begin
            next_ptr = '0;
        end else begin
            next_ptr = p + PTR_W'(1);
        end
    endfunction

    assign o_cmd          = r_slot[r_rd];
    assign o_q_stat.full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_q_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* design/xfse_back.sv */
`timescale 1ns / 1ps
// back part: walks the head command byte by byte into the output register
// depends on xfse_pkg
module xfse_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xfse_pkg::t_cmd    i_cmd,
    input  xfse_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_last
);
    import xfse_pkg::*;

    logic [3:0] r_idx;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_valid;
    logic [3:0] len;
    logic [3:0] pos;
    logic [3:0] idx_m1;
    logic [3:0] idx_m3;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       load;

    function automatic logic [7:0] word_byte(input logic [WORD_BITS-1:0] w,
                                             input logic [2:0] sel);
        word_byte = w[sel*8 +: 8];
    endfunction

    assign idx_m1 = r_idx - 4'd1;
    assign idx_m3 = r_idx - 4'(HEADER_BYTES);
    // window bytes go most significant first
    assign pos    = 4'd7 - {1'b0, i_cmd.lead} - idx_m3;

    always_comb begin
        case (i_cmd.kind)
            K_RAW:    len = 4'(WORD_BYTES);
            K_ZERO:   len = 4'd1;
            K_NARROW: len = 4'(HEADER_BYTES) + {1'b0, i_cmd.span};
            K_WIDE:   len = 4'(WIDE_LIMIT);
            default:  len = 4'd1;
        endcase
    end

    always_comb begin
        case (i_cmd.kind)
            K_RAW:    cur_byte = word_byte(i_cmd.word, r_idx[2:0]);
            K_ZERO:   cur_byte = MARK_ZERO;
            K_NARROW: begin
                if (r_idx == 4'd0) begin
                    cur_byte = MARK_NARROW;
                end else if (r_idx == 4'd1) begin
                    cur_byte = {5'd0, i_cmd.lead};
                end else if (r_idx == 4'd2) begin
                    cur_byte = {5'd0, i_cmd.span};
                end else begin
                    cur_byte = word_byte(i_cmd.word, pos[2:0]);
                end
            end
            K_WIDE: begin
                if (r_idx == 4'd0) begin
                    cur_byte = MARK_WIDE;
                end else begin
                    cur_byte = word_byte(i_cmd.word, idx_m1[2:0]);
                end
            end
            default:  cur_byte = MARK_ZERO;
        endcase
    end

    assign cur_last = (r_idx == len - 4'd1);
    assign load     = !i_q_stat.empty && (!r_valid || i_ready);
    assign o_pop    = load && cur_last;

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_byte_last = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= cur_last ? 4'd0 : r_idx + 4'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

/* design/xor_float_series_encoder.sv */
`timescale 1ns / 1ps
// top level of the xor float series encoder: front, command queue, back
// depends on xfse_pkg, xfse_in_if, xfse_out_if, xfse_front, xfse_fifo, xfse_back
//
//   channel  dir  beat carries                          handshake
//   i_in     in   value_bits[63:0], first_of_series     valid/ready
//   o_out    out  out_byte[7:0], byte_last              valid/ready
//
// one sample gives 1 to 9 output bytes; the back moves one byte per cycle through
// the byte-wide output register while o_out is ready and the queue holds a command
// the front takes a beat every cycle while the four-entry command queue has room
// a sample passes from its input beat through the command queue into the output
// register; earlier commands in the queue or a stall on o_out can hold it back
// synchronous active-low reset empties the queue, clears the sample history and
// holds i_in ready low
// a stall on o_out holds the output register; the queue absorbs input meanwhile
module xor_float_series_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xfse_in_if.sink    i_in,
    xfse_out_if.source o_out
);
    import xfse_pkg::*;

    t_cmd    q_wr_cmd;
    t_cmd    q_head;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;

    // front: xor with history, zero-byte counts, choice of form
    xfse_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in.valid),
        .o_ready           (i_in.ready),
        .i_value_bits      (i_in.value_bits),
        .i_first_of_series (i_in.first_of_series),
        .i_q_stat          (q_stat),
        .o_push            (q_push),
        .o_cmd             (q_wr_cmd)
    );

    // commands waiting for the back
    xfse_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_cmd    (q_wr_cmd),
        .i_pop    (q_pop),
        .o_cmd    (q_head),
        .o_q_stat (q_stat)
    );

    // back: byte sequencer and output register
    xfse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_head),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_out_byte  (o_out.out_byte),
        .o_byte_last (o_out.byte_last)
    );

    // queue never pops while empty
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("command queue popped while empty");

    // queue never pushed while full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("command queue pushed while full");

    // a pop always comes with a byte marked last in the next output beat
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_out.valid && o_out.byte_last))
        else $error("command retired without a last byte");

endmodule
